@@ rtl/core/lru_cache_lookup_macros.svh @@
// ----------------------------------------------------------------------------
// lru_cache_lookup_macros.svh
// assertion helpers shared by the lru cache checker
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_LOOKUP_MACROS_SVH
`define LRU_CACHE_LOOKUP_MACROS_SVH

// same-cycle implication
`define LCL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru cache assertion failed");

// implication checked a fixed number of cycles later
`define LCL_ASSERT_DLY(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("lru cache assertion failed");

`endif

@@ rtl/core/lcl_pkg.sv @@
// ----------------------------------------------------------------------------
// lcl_pkg
// types and constants shared by the lru cache lookup block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcl_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AGE_W   = IDX_W;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int APB_AW  = 3;
   localparam int APB_DW  = 32;
   localparam int REG_W   = 1;

   localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(16);
   localparam logic [REG_W-1:0] REG_CAPACITY = 1'b0;
   localparam logic             CMD_GET      = 1'b0;
   localparam logic             CMD_SET      = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic commit;
   } ctrl_cmd_type;

endpackage

@@ rtl/core/lcl_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcl_ctrl
// sequencer: lookup on accept, then the update state for each beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output lcl_pkg::ctrl_cmd_type cmd
);
   import lcl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_UPDATE: begin
            busy       = 1'b1;
            cmd.commit = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/lcl_dpath.sv @@
// ----------------------------------------------------------------------------
// lcl_dpath
// entry store, parallel key match, recency ranks and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcl_dpath #(
   parameter int KEY_BITS  = 16,
   parameter int DATA_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lcl_pkg::ctrl_cmd_type      cmd,
   input  logic [lcl_pkg::CAP_W-1:0]  capacity,
   input  logic                       req_cmd,
   input  logic [KEY_BITS-1:0]        req_key,
   input  logic [DATA_BITS-1:0]       req_value,
   output logic                       rsp_strobe,
   output logic                       rsp_hit,
   output logic [DATA_BITS-1:0]       rsp_read_value,
   output logic                       rsp_evicted
);
   import lcl_pkg::*;

   // entry store
   logic [KEY_BITS-1:0]  key_ff  [ENTRIES];
   logic [KEY_BITS-1:0]  key_in  [ENTRIES];
   logic [DATA_BITS-1:0] data_ff [ENTRIES];
   logic [DATA_BITS-1:0] data_in [ENTRIES];
   logic [AGE_W-1:0]     age_ff  [ENTRIES];
   logic [AGE_W-1:0]     age_in  [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   valid_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   // lookup stage
   logic                 lk_set_ff,    lk_set_in;
   logic [KEY_BITS-1:0]  lk_key_ff,    lk_key_in;
   logic [DATA_BITS-1:0] lk_value_ff,  lk_value_in;
   logic                 lk_hit_ff,    lk_hit_in;
   logic [DATA_BITS-1:0] lk_read_ff,   lk_read_in;
   logic [IDX_W-1:0]     lk_slot_ff,   lk_slot_in;
   logic [CNT_W-1:0]     lk_rank_ff,   lk_rank_in;
   logic                 lk_touch_ff,  lk_touch_in;
   logic                 lk_insert_ff, lk_insert_in;
   logic                 lk_evict_ff,  lk_evict_in;

   // result register
   logic                 strobe_ff,  strobe_in;
   logic                 hit_ff,     hit_in;
   logic [DATA_BITS-1:0] read_ff,    read_in;
   logic                 evicted_ff, evicted_in;

   logic [ENTRIES-1:0]   match;
   logic                 hit;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     free_idx;
   logic [IDX_W-1:0]     victim_idx;
   logic [CNT_W-1:0]     oldest;
   logic [CNT_W-1:0]     cap_eff;
   logic                 is_set;
   logic                 full;

   always_comb begin
      if (capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if (CNT_W'(capacity) > CNT_W'(ENTRIES)) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = CNT_W'(capacity);
      end
   end

   // parallel match, lowest free slot, entry holding the oldest rank
   always_comb begin
      oldest     = CNT_W'(count_ff - 1'b1);
      match      = '0;
      hit_idx    = '0;
      free_idx   = '0;
      victim_idx = '0;
      for (int j = ENTRIES - 1; j >= 0; j--) begin
         match[j] = valid_ff[j] && (key_ff[j] == req_key);
         if (match[j]) begin
            hit_idx = IDX_W'(j);
         end
         if (!valid_ff[j]) begin
            free_idx = IDX_W'(j);
         end
         if (valid_ff[j] && (CNT_W'(age_ff[j]) == oldest)) begin
            victim_idx = IDX_W'(j);
         end
      end
      hit    = |match;
      is_set = (req_cmd == CMD_SET);
      full   = (count_ff >= cap_eff);
   end

   always_comb begin
      lk_set_in    = lk_set_ff;
      lk_key_in    = lk_key_ff;
      lk_value_in  = lk_value_ff;
      lk_hit_in    = lk_hit_ff;
      lk_read_in   = lk_read_ff;
      lk_slot_in   = lk_slot_ff;
      lk_rank_in   = lk_rank_ff;
      lk_touch_in  = lk_touch_ff;
      lk_insert_in = lk_insert_ff;
      lk_evict_in  = lk_evict_ff;
      if (cmd.load) begin
         lk_set_in    = is_set;
         lk_key_in    = req_key;
         lk_value_in  = req_value;
         lk_hit_in    = hit;
         lk_read_in   = (hit && !is_set) ? data_ff[hit_idx] : '0;
         lk_touch_in  = hit || is_set;
         lk_insert_in = is_set && !hit && !full;
         lk_evict_in  = is_set && !hit && full;
         if (hit) begin
            lk_slot_in = hit_idx;
            lk_rank_in = CNT_W'(age_ff[hit_idx]);
         end else if (full) begin
            lk_slot_in = victim_idx;
            lk_rank_in = oldest;
         end else begin
            lk_slot_in = free_idx;
            lk_rank_in = count_ff;
         end
      end
   end

   // commit: move touched entry to front, age the younger ones, store set data and new keys
   always_comb begin
      key_in     = key_ff;
      data_in    = data_ff;
      age_in     = age_ff;
      valid_in   = valid_ff;
      count_in   = count_ff;
      strobe_in  = cmd.commit;
      hit_in     = hit_ff;
      read_in    = read_ff;
      evicted_in = evicted_ff;
      if (cmd.commit) begin
         hit_in     = lk_hit_ff;
         read_in    = lk_read_ff;
         evicted_in = lk_evict_ff;
         if (lk_touch_ff) begin
            for (int j = 0; j < ENTRIES; j++) begin
               if (valid_ff[j] && (IDX_W'(j) != lk_slot_ff)
                   && (CNT_W'(age_ff[j]) < lk_rank_ff)) begin
                  age_in[j] = AGE_W'(age_ff[j] + 1'b1);
               end
            end
            age_in[lk_slot_ff] = '0;
         end
         if (lk_set_ff) begin
            data_in[lk_slot_ff] = lk_value_ff;
         end
         if (lk_insert_ff || lk_evict_ff) begin
            key_in[lk_slot_ff] = lk_key_ff;
         end
         if (lk_insert_ff) begin
            valid_in[lk_slot_ff] = 1'b1;
            count_in             = CNT_W'(count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         for (int j = 0; j < ENTRIES; j++) begin
            age_ff[j] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         age_ff    <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      data_ff      <= data_in;
      lk_set_ff    <= lk_set_in;
      lk_key_ff    <= lk_key_in;
      lk_value_ff  <= lk_value_in;
      lk_hit_ff    <= lk_hit_in;
      lk_read_ff   <= lk_read_in;
      lk_slot_ff   <= lk_slot_in;
      lk_rank_ff   <= lk_rank_in;
      lk_touch_ff  <= lk_touch_in;
      lk_insert_ff <= lk_insert_in;
      lk_evict_ff  <= lk_evict_in;
      hit_ff       <= hit_in;
      read_ff      <= read_in;
      evicted_ff   <= evicted_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_read_value = read_ff;
   assign rsp_evicted    = evicted_ff;

endmodule

@@ rtl/core/lru_cache_lookup.sv @@
// ----------------------------------------------------------------------------
// lru_cache_lookup
// key-value store with least-recently-used replacement
//
//   channel   dir   ports                                         handshake
//   request   in    req_cmd, req_key, req_value                   start / busy
//   response  out   rsp_hit, rsp_read_value, rsp_evicted          rsp_strobe
//   csr       in    psel, penable, pwrite, paddr, pwdata, prdata  pready
//
// the key match runs on the accepted beat, and the recency update and result
// register load in the following cycle
// busy is high for that one update cycle; a new beat is taken the cycle after
// the response strobe appears in the cycle after the update
// reset clears valid bits and recency ranks and sets capacity to 16; no clearing pass
// the receiver cannot stall, so responses never back up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_cache_lookup #(
   parameter int KEY_BITS  = 16,
   parameter int DATA_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic [KEY_BITS-1:0]         req_key,
   input  logic [DATA_BITS-1:0]        req_value,
   output logic                        rsp_strobe,
   output logic                        rsp_hit,
   output logic [DATA_BITS-1:0]        rsp_read_value,
   output logic                        rsp_evicted,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lcl_pkg::APB_AW-1:0]  paddr,
   input  logic [lcl_pkg::APB_DW-1:0]  pwdata,
   output logic [lcl_pkg::APB_DW-1:0]  prdata,
   output logic                        pready
);
   import lcl_pkg::*;

   ctrl_cmd_type     cmd;
   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic [REG_W-1:0] reg_idx;
   logic             csr_wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[APB_AW-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr && (reg_idx == REG_CAPACITY)) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_CAPACITY) begin
         prdata = APB_DW'(capacity_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   lcl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lcl_dpath #(
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .capacity       (capacity_ff),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .rsp_evicted    (rsp_evicted)
   );

endmodule

@@ rtl/core/lcl_checker.sv @@
// ----------------------------------------------------------------------------
// lcl_checker
// port-level checks on beat timing and response fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_cache_lookup_macros.svh"

module lcl_checker #(
   parameter int DATA_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input logic                 rsp_hit,
   input logic [DATA_BITS-1:0] rsp_read_value,
   input logic                 rsp_evicted
);

   `LCL_ASSERT_DLY(a_accept_busy, clock, reset, start && !busy, 1, busy)
   `LCL_ASSERT_DLY(a_one_response, clock, reset, start && !busy, 2, rsp_strobe)
   `LCL_ASSERT_IMP(a_miss_no_data, clock, reset, rsp_strobe && !rsp_hit, rsp_read_value == '0)
   `LCL_ASSERT_IMP(a_evict_on_miss, clock, reset, rsp_strobe && rsp_evicted, !rsp_hit)

endmodule

bind lru_cache_lookup lcl_checker #(
   .DATA_BITS (DATA_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_hit        (rsp_hit),
   .rsp_read_value (rsp_read_value),
   .rsp_evicted    (rsp_evicted)
);

@@ bench/tb_lru_cache_lookup.sv @@
// ----------------------------------------------------------------------------
// tb_lru_cache_lookup
// self-checking bench for the lru key-value lookup block
//
// gets and sets go in through the start/busy port, and each beat is checked
// against an in-bench lru predictor. the predictor keeps its own slot keys,
// data, valid bits, recency ranks and capacity setting. the capacity register
// is written over apb only while the block is idle, and read back after each
// write. the run covers extreme capacities, an overwrite, eviction and
// lowering the capacity below the number in use. random traffic draws keys
// from small pools so that hits and evictions are frequent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_cache_lookup;
   import lcl_pkg::*;

   localparam int KEY_W      = 16;
   localparam int DATA_W     = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int PRINT_MAX  = 40;
   localparam logic [APB_AW-1:0] CAPACITY_ADDR = APB_AW'(4 * int'(REG_CAPACITY));

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
   } lookup_result_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   logic              req_cmd   = CMD_GET;
   logic [KEY_W-1:0]  req_key   = '0;
   logic [DATA_W-1:0] req_value = '0;
   logic              rsp_strobe;
   logic              rsp_hit;
   logic [DATA_W-1:0] rsp_read_value;
   logic              rsp_evicted;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [APB_AW-1:0] paddr     = '0;
   logic [APB_DW-1:0] pwdata    = '0;
   logic [APB_DW-1:0] prdata;
   logic              pready;

   // predictor state
   logic [KEY_W-1:0]  slot_key   [ENTRIES];
   logic [DATA_W-1:0] slot_data  [ENTRIES];
   bit                slot_valid [ENTRIES];
   int                slot_rank  [ENTRIES];
   logic [CAP_W-1:0]  cap_setting = CAP_RESET;

   lookup_result_type pending_lookups[$];
   int unsigned    mismatches  = 0;
   int unsigned    idle_cycles = 0;
   bit             sender_burst = 1'b0;

   lru_cache_lookup #(
      .KEY_BITS  (KEY_W),
      .DATA_BITS (DATA_W)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .rsp_evicted    (rsp_evicted),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= PRINT_MAX)
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
   endtask

   // make slot s the most recent; every younger valid slot ages by one
   function automatic void promote_slot(int s);
      int a;
      a = slot_rank[s];
      for (int j = 0; j < ENTRIES; j++)
         if (j != s && slot_valid[j] && slot_rank[j] < a)
            slot_rank[j]++;
      slot_rank[s] = 0;
   endfunction

   function automatic lookup_result_type predict_lookup(input logic cmd,
                                                        input logic [KEY_W-1:0] key,
                                                        input logic [DATA_W-1:0] value);
      lookup_result_type r;
      int limit, in_use, found, free_slot, victim;
      r = '0;
      limit = (cap_setting == 0) ? 1 : (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);
      in_use = 0;
      found = -1;
      free_slot = -1;
      victim = -1;
      for (int j = 0; j < ENTRIES; j++) begin
         if (slot_valid[j]) begin
            in_use++;
            if (found < 0 && slot_key[j] == key)
               found = j;
            if (victim < 0 || slot_rank[j] > slot_rank[victim])
               victim = j;
         end else if (free_slot < 0) begin
            free_slot = j;
         end
      end
      r.hit = (found >= 0);
      if (cmd == CMD_GET) begin
         if (found >= 0) begin
            r.read_value = slot_data[found];
            promote_slot(found);
         end
      end else if (found >= 0) begin
         slot_data[found] = value;
         promote_slot(found);
      end else if (in_use >= limit || free_slot < 0) begin
         // capacity is at least one, so a victim always exists here
         slot_key[victim]  = key;
         slot_data[victim] = value;
         promote_slot(victim);
         r.evicted = 1'b1;
      end else begin
         slot_key[free_slot]   = key;
         slot_data[free_slot]  = value;
         slot_rank[free_slot]  = in_use;
         slot_valid[free_slot] = 1'b1;
         promote_slot(free_slot);
      end
      return r;
   endfunction

   task automatic wait_drain();
      while (pending_lookups.size() != 0)
         @(posedge clock);
   endtask

   // settle: leave start low afterwards and wait for every beat to come back
   task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                               input logic [DATA_W-1:0] value, input bit settle);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 17);
      if (settle && gap == 0)
         gap = 1;
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (busy);
      pending_lookups.push_back(predict_lookup(cmd, key, value));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (settle)
         wait_drain();
   endtask

   task automatic csr_access(input logic wr, input logic [APB_AW-1:0] addr,
                             input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_capacity();
      logic [APB_DW-1:0] rdata;
      csr_access(1'b0, CAPACITY_ADDR, '0, rdata);
      if (rdata !== APB_DW'(cap_setting))
         report_mismatch("capacity readback", rdata, cap_setting);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      logic [APB_DW-1:0] wdata;
      logic [APB_DW-1:0] rdata;
      wait_drain();
      repeat (4) @(posedge clock);
      wdata = $urandom;
      wdata[CAP_W-1:0] = value;
      csr_access(1'b1, CAPACITY_ADDR, wdata, rdata);
      cap_setting = value;
      @(posedge clock);
      check_capacity();
   endtask

   task automatic test_capacity_register();
      check_capacity();
      write_capacity(5'd31);
      write_capacity(5'd0);
      write_capacity(CAP_RESET);
   endtask

   task automatic test_empty_cache();
      send_request(CMD_GET, 16'h0000, 16'hFFFF, 1'b0);
      send_request(CMD_GET, 16'hFFFF, 16'h0000, 1'b1);
   endtask

   task automatic test_store_and_fetch();
      send_request(CMD_SET, 16'h0000, 16'hFFFF, 1'b0);
      send_request(CMD_SET, 16'hFFFF, 16'h0000, 1'b0);
      send_request(CMD_GET, 16'h0000, 16'h0000, 1'b0);
      send_request(CMD_GET, 16'hFFFF, 16'hFFFF, 1'b0);
      // overwrite of a present key
      send_request(CMD_SET, 16'h0000, 16'h1234, 1'b0);
      send_request(CMD_GET, 16'h0000, 16'h0000, 1'b1);
   endtask

   task automatic test_single_entry();
      // capacity now below the number in use
      write_capacity(5'd1);
      send_request(CMD_SET, 16'h5555, 16'hA5A5, 1'b0);
      send_request(CMD_GET, 16'h5555, 16'h0000, 1'b1);
      // zero capacity behaves as one
      write_capacity(5'd0);
      send_request(CMD_SET, 16'hAAAA, 16'h5A5A, 1'b0);
      send_request(CMD_GET, 16'h5555, 16'h0000, 1'b1);
   endtask

   task automatic test_fill_and_evict();
      write_capacity(5'd3);
      send_request(CMD_SET, 16'h0F0F, 16'h1111, 1'b0);
      send_request(CMD_SET, 16'hF0F0, 16'h2222, 1'b0);
      send_request(CMD_GET, 16'h0F0F, 16'h0000, 1'b0);
      send_request(CMD_SET, 16'h3C3C, 16'h3333, 1'b0);
      send_request(CMD_GET, 16'hAAAA, 16'h0000, 1'b0);
      send_request(CMD_GET, 16'hF0F0, 16'h0000, 1'b1);
   endtask

   task automatic test_random_traffic();
      logic [CAP_W-1:0] settings[8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd8, 5'd2};
      logic [KEY_W-1:0] key_pool[$];
      int               pool_size;
      logic             cmd;
      logic [KEY_W-1:0] key;
      foreach (settings[p]) begin
         write_capacity(settings[p]);
         pool_size = ((settings[p] == 0) ? 1 : (settings[p] > ENTRIES) ? ENTRIES :
                      int'(settings[p])) + $urandom_range(1, 8);
         key_pool.delete();
         repeat (pool_size) key_pool.push_back(KEY_W'($urandom));
         for (int i = 0; i < 88; i++) begin
            if (i % 16 == 0)
               sender_burst = ($urandom_range(0, 3) == 0);
            cmd = $urandom_range(0, 1) ? CMD_SET : CMD_GET;
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                              : key_pool[$urandom_range(0, pool_size - 1)];
            send_request(cmd, key, DATA_W'($urandom), i == 87 || $urandom_range(0, 39) == 0);
         end
      end
      sender_burst = 1'b0;
   endtask

   always @(posedge clock) begin : check_beat
      lookup_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_read_value !== want.read_value)
               report_mismatch("read_value", rsp_read_value, want.read_value);
            if (rsp_evicted !== want.evicted)
               report_mismatch("evicted", rsp_evicted, want.evicted);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      foreach (slot_valid[j]) begin
         slot_key[j]   = '0;
         slot_data[j]  = '0;
         slot_valid[j] = 1'b0;
         slot_rank[j]  = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_capacity_register();
      test_empty_cache();
      test_store_and_fetch();
      test_single_entry();
      test_fill_and_evict();
      test_random_traffic();
      wait_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
